// File: src/tlptw_pkg.sv
// Shared types and constants for the two-level page table map and walk block.
// No dependencies; compile first.
package tlptw_pkg;

  localparam int OFFSET_BITS = 12;
  localparam int VA_BITS     = 22;
  localparam int FRAME_BITS  = 20;
  localparam int FLAG_BITS   = 12;
  localparam int PADDR_BITS  = 32;
  localparam int PAGE_BITS   = 10;

  localparam logic [FLAG_BITS-1:0] PRESENT = 12'h001;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_MAP    = 1'b1;

  localparam logic [1:0] ST_DONE        = 2'd0;
  localparam logic [1:0] ST_DIR_ABSENT  = 2'd1;
  localparam logic [1:0] ST_PAGE_ABSENT = 2'd2;
  localparam logic [1:0] ST_MAPPED      = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [VA_BITS-1:0]    virt_addr;
    logic [FRAME_BITS-1:0] phys_frame;
    logic [FLAG_BITS-1:0]  page_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PADDR_BITS-1:0] phys_addr;
    logic                  flush_valid;
    logic [PAGE_BITS-1:0]  flush_page;
  } rsp_t;

endpackage

// File: src/tlptw_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on tlptw_pkg.
interface tlptw_req_if;
  import tlptw_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tlptw_rsp_if;
  import tlptw_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/two_level_page_table_map_walk_top.sv
// Two-level page table map and walk: directory and page table memories with FSM.
// Depends on tlptw_pkg and the channel interfaces in tlptw_if.sv.
//
// The block holds a page directory and all page tables in two single-port-write
// synchronous memories. A virtual address splits into a directory index, a table
// index and a 12-bit offset; bits above the directory index are ignored. Each
// item goes through accept, directory read and page entry read; the page entry
// is used only when the directory entry is present. A lookup that finds its
// directory entry absent ends after the directory read. A map whose directory
// entry is absent replaces the page entry read with a clear of that page table,
// one entry per cycle through the page memory write port, writing the new entry
// at its own slot. After reset the directory is cleared one entry per cycle,
// with req.ready low. One item is in work at a time; a finished result waits in
// the output register while the next item is accepted. If that register is
// still full when the next result is ready, the result waits in a holding
// register and req.ready stays low until it moves out.
module two_level_page_table_map_walk_top #(
  parameter int DIR_INDEX_BITS   = 4,
  parameter int TABLE_INDEX_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  tlptw_req_if.sink   req,
  tlptw_rsp_if.source rsp
);
  import tlptw_pkg::*;

  localparam int D         = DIR_INDEX_BITS;
  localparam int T         = TABLE_INDEX_BITS;
  localparam int PW        = D + T;
  localparam int VA_W      = (OFFSET_BITS + PW > VA_BITS) ? OFFSET_BITS + PW : VA_BITS;
  localparam int CNT_W     = (D > T) ? D : T;
  localparam int DIR_DEPTH = 1 << D;
  localparam int PT_DEPTH  = 1 << PW;

  typedef enum logic [2:0] {
    S_CLR_DIR, S_IDLE, S_DIR, S_CLR_TBL, S_PAGE, S_HOLD
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  req_t                  r;
  rsp_t                  hold;
  rsp_t                  out_data;
  logic                  out_valid;

  logic [FLAG_BITS-1:0]  dir_mem [DIR_DEPTH];
  logic [PADDR_BITS-1:0] pt_mem  [PT_DEPTH];
  logic [FLAG_BITS-1:0]  dir_rdata;
  logic [PADDR_BITS-1:0] pt_rdata;

  logic                  dir_we;
  logic [D-1:0]          dir_waddr;
  logic [FLAG_BITS-1:0]  dir_wdata;
  logic                  pt_we;
  logic [PW-1:0]         pt_waddr;
  logic [PADDR_BITS-1:0] pt_wdata;

  logic [VA_W-1:0]       in_va;
  logic [VA_W-1:0]       r_va;
  logic [D-1:0]          in_di;
  logic [D-1:0]          r_di;
  logic [T-1:0]          r_ti;
  logic [PW-1:0]         r_slot;
  logic [PADDR_BITS-1:0] new_entry;
  logic                  out_free;
  logic                  res_vld;
  rsp_t                  res;

  assign in_va     = VA_W'(req.data.virt_addr);
  assign r_va      = VA_W'(r.virt_addr);
  assign in_di     = in_va[OFFSET_BITS + T +: D];
  assign r_di      = r_va[OFFSET_BITS + T +: D];
  assign r_ti      = r_va[OFFSET_BITS +: T];
  assign r_slot    = r_va[OFFSET_BITS +: PW];
  assign new_entry = {r.phys_frame, r.page_flags | PRESENT};
  assign out_free  = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_rdata <= dir_mem[in_di];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[r_slot];
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = r_di;
    dir_wdata = r.page_flags | PRESENT;
    pt_we     = 1'b0;
    pt_waddr  = r_slot;
    pt_wdata  = new_entry;
    res_vld   = 1'b0;
    res       = '0;
    unique case (state)
      S_CLR_DIR: begin
        dir_we    = 1'b1;
        dir_waddr = cnt[D-1:0];
        dir_wdata = '0;
      end
      S_DIR: begin
        if (dir_rdata == '0) begin
          if (r.req_type == REQ_LOOKUP) begin
            res_vld    = 1'b1;
            res.status = ST_DIR_ABSENT;
          end else begin
            dir_we = 1'b1;
          end
        end
      end
      S_CLR_TBL: begin
        pt_we    = 1'b1;
        pt_waddr = {r_di, cnt[T-1:0]};
        pt_wdata = (cnt[T-1:0] == r_ti) ? new_entry : '0;
        if (cnt[T-1:0] == {T{1'b1}}) begin
          res_vld         = 1'b1;
          res.status      = ST_DONE;
          res.flush_valid = 1'b1;
          res.flush_page  = r.virt_addr[VA_BITS-1:OFFSET_BITS];
        end
      end
      S_PAGE: begin
        res_vld = 1'b1;
        if (r.req_type == REQ_LOOKUP) begin
          if (pt_rdata == '0) begin
            res.status = ST_PAGE_ABSENT;
          end else begin
            res.status    = ST_DONE;
            res.phys_addr = {pt_rdata[PADDR_BITS-1:OFFSET_BITS],
                             r.virt_addr[OFFSET_BITS-1:0]};
          end
        end else if (pt_rdata != '0) begin
          res.status = ST_MAPPED;
        end else begin
          pt_we           = 1'b1;
          res.status      = ST_DONE;
          res.flush_valid = 1'b1;
          res.flush_page  = r.virt_addr[VA_BITS-1:OFFSET_BITS];
        end
      end
      S_IDLE, S_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_DIR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR_DIR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt[D-1:0] == {D{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            r     <= req.data;
            state <= S_DIR;
          end
        end
        S_DIR: begin
          if (dir_rdata != '0) begin
            state <= S_PAGE;
          end else if (r.req_type == REQ_MAP) begin
            cnt   <= '0;
            state <= S_CLR_TBL;
          end
        end
        S_CLR_TBL: begin
          cnt <= cnt + CNT_W'(1);
        end
        S_PAGE: begin
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (res_vld) begin
        if (out_free) begin
          state <= S_IDLE;
        end else begin
          hold  <= res;
          state <= S_HOLD;
        end
      end
      if (res_vld && out_free) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else if (state == S_HOLD && out_free) begin
        out_data  <= hold;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/tlptw_checker.sv
// Port-level assertions for the page table map and walk top level, with bind.
// Depends on tlptw_pkg and two_level_page_table_map_walk_top.
module tlptw_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input tlptw_pkg::rsp_t  rsp_data
);
  import tlptw_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response item dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("response item changed while stalled");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during directory clear");

  a_one_in_work: assert property (@(posedge clk)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in work");

  a_flush_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.flush_valid |->
      rsp_data.status == ST_DONE && rsp_data.phys_addr == '0)
    else $error("flush with inconsistent status or address");

endmodule

bind two_level_page_table_map_walk_top tlptw_checker u_tlptw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
